/* hw/rtl/sbi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared constants and types for the segment/box intersection pipeline.
// ----------------------------------------------------------------------------
package sbi_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_CORNER0_X = 2'd0;
  localparam logic [1:0] REG_CORNER0_Y = 2'd1;
  localparam logic [1:0] REG_CORNER1_X = 2'd2;
  localparam logic [1:0] REG_CORNER1_Y = 2'd3;

  // Per-stage load enables of the datapath pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

/* hw/rtl/segment_box_intersect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_intersect
// Segment versus axis-aligned box test with exact rational slab clipping.
// ----------------------------------------------------------------------------
// Accepts one segment per clock while in_stall is low and returns one result
// per segment, in order. The datapath is a five-stage pipeline: coordinate
// differences and range checks, direction normalization, clamping to [0,1],
// four COORD_BITS x COORD_BITS cross multiplications, and the final compare.
// Each stage holds while the one after it is full and stalled, so empty
// stages still take new segments while a result waits on out_stall. Box
// corners must be written over the APB port only while no segment is in
// flight; the block does not enforce it. They apply to the next transfer.
module segment_box_intersect #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbi_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sbi_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sbi_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  // segment input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_BITS-1:0]   in_start_x,
  input  logic signed [COORD_BITS-1:0]   in_start_y,
  input  logic signed [COORD_BITS-1:0]   in_end_x,
  input  logic signed [COORD_BITS-1:0]   in_end_y,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic                           out_start_inside,
  output logic                           out_end_inside
);
  import sbi_pkg::*;

  logic signed [COORD_BITS-1:0] xlo, xhi, ylo, yhi;
  logic                         v1_r, v2_r, v3_r, v4_r, v5_r;
  pipe_en_t                     en;

  logic [COORD_BITS-1:0] x_lo_num, x_lo_den, x_hi_num, x_hi_den;
  logic [COORD_BITS-1:0] y_lo_num, y_lo_den, y_hi_num, y_hi_den;
  logic                  x_miss, y_miss, xa_in, xb_in, ya_in, yb_in;

  assign pready = 1'b1;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    en.s5 = !v5_r || !out_stall;
    en.s4 = !v4_r || en.s5;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_stall  = !en.s1;
  assign out_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
      if (en.s5) v5_r <= v4_r;
    end
  end

  sbi_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .xlo     (xlo),
    .xhi     (xhi),
    .ylo     (ylo),
    .yhi     (yhi)
  );

  sbi_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk      (clk),
    .en       (en),
    .a_i      (in_start_x),
    .b_i      (in_end_x),
    .lo_i     (xlo),
    .hi_i     (xhi),
    .t_lo_num (x_lo_num),
    .t_lo_den (x_lo_den),
    .t_hi_num (x_hi_num),
    .t_hi_den (x_hi_den),
    .miss     (x_miss),
    .a_in     (xa_in),
    .b_in     (xb_in)
  );

  sbi_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk      (clk),
    .en       (en),
    .a_i      (in_start_y),
    .b_i      (in_end_y),
    .lo_i     (ylo),
    .hi_i     (yhi),
    .t_lo_num (y_lo_num),
    .t_lo_den (y_lo_den),
    .t_hi_num (y_hi_num),
    .t_hi_den (y_hi_den),
    .miss     (y_miss),
    .a_in     (ya_in),
    .b_in     (yb_in)
  );

  sbi_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
    .clk          (clk),
    .en           (en),
    .x_lo_num     (x_lo_num),
    .x_lo_den     (x_lo_den),
    .x_hi_num     (x_hi_num),
    .x_hi_den     (x_hi_den),
    .y_lo_num     (y_lo_num),
    .y_lo_den     (y_lo_den),
    .y_hi_num     (y_hi_num),
    .y_hi_den     (y_hi_den),
    .x_miss       (x_miss),
    .y_miss       (y_miss),
    .start_in     (xa_in && ya_in),
    .end_in       (xb_in && yb_in),
    .hit          (out_hit),
    .start_inside (out_start_inside),
    .end_inside   (out_end_inside)
  );

endmodule

/* hw/rtl/sbi_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_cfg
// APB register file holding the two box corners; presents the box as
// ordered low/high bounds per axis.
// ----------------------------------------------------------------------------
module sbi_cfg #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sbi_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [sbi_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [sbi_pkg::CFG_DATA_W-1:0]       prdata,
  output logic signed [COORD_BITS-1:0]         xlo,
  output logic signed [COORD_BITS-1:0]         xhi,
  output logic signed [COORD_BITS-1:0]         ylo,
  output logic signed [COORD_BITS-1:0]         yhi
);
  import sbi_pkg::*;

  logic [COORD_BITS-1:0] corner0_x_r;
  logic [COORD_BITS-1:0] corner0_y_r;
  logic [COORD_BITS-1:0] corner1_x_r;
  logic [COORD_BITS-1:0] corner1_y_r;
  logic [1:0]            reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner0_x_r <= '0;
      corner0_y_r <= '0;
      corner1_x_r <= '0;
      corner1_y_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CORNER0_X: corner0_x_r <= pwdata[COORD_BITS-1:0];
        REG_CORNER0_Y: corner0_y_r <= pwdata[COORD_BITS-1:0];
        REG_CORNER1_X: corner1_x_r <= pwdata[COORD_BITS-1:0];
        REG_CORNER1_Y: corner1_y_r <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CORNER0_X: prdata = CFG_DATA_W'(corner0_x_r);
      REG_CORNER0_Y: prdata = CFG_DATA_W'(corner0_y_r);
      REG_CORNER1_X: prdata = CFG_DATA_W'(corner1_x_r);
      REG_CORNER1_Y: prdata = CFG_DATA_W'(corner1_y_r);
      default:       prdata = '0;
    endcase
  end

  // Order the corners per axis
  always_comb begin
    if ($signed(corner0_x_r) < $signed(corner1_x_r)) begin
      xlo = $signed(corner0_x_r);
      xhi = $signed(corner1_x_r);
    end else begin
      xlo = $signed(corner1_x_r);
      xhi = $signed(corner0_x_r);
    end
    if ($signed(corner0_y_r) < $signed(corner1_y_r)) begin
      ylo = $signed(corner0_y_r);
      yhi = $signed(corner1_y_r);
    end else begin
      ylo = $signed(corner1_y_r);
      yhi = $signed(corner0_y_r);
    end
  end

endmodule

/* hw/rtl/sbi_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_axis
// One axis of the slab test over three stages: differences and range
// checks, direction normalization, then clamping of the entry and exit
// parameters to [0,1] as fractions num/den with den > 0.
// ----------------------------------------------------------------------------
module sbi_axis #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  sbi_pkg::pipe_en_t            en,
  input  logic signed [COORD_BITS-1:0] a_i,
  input  logic signed [COORD_BITS-1:0] b_i,
  input  logic signed [COORD_BITS-1:0] lo_i,
  input  logic signed [COORD_BITS-1:0] hi_i,
  output logic [COORD_BITS-1:0]        t_lo_num,
  output logic [COORD_BITS-1:0]        t_lo_den,
  output logic [COORD_BITS-1:0]        t_hi_num,
  output logic [COORD_BITS-1:0]        t_hi_den,
  output logic                         miss,
  output logic                         a_in,
  output logic                         b_in
);
  import sbi_pkg::*;

  localparam int W = COORD_BITS;

  // stage 1
  logic                a_in1_r, b_in1_r;
  logic signed [W:0]   d1_r, n1_1_r, n2_1_r;
  logic signed [W:0]   a_ext, b_ext, lo_ext, hi_ext;
  // stage 2
  logic                a_in2_r, b_in2_r, zero2_r;
  logic [W-1:0]        mag2_r;
  logic signed [W:0]   f1_2_r, f2_2_r;
  logic signed [W:0]   d_neg, n1_neg, n2_neg;
  logic                dir_neg;
  // stage 3
  logic                a_in3_r, b_in3_r, miss3_r;
  logic [W-1:0]        lo_num3_r, lo_den3_r, hi_num3_r, hi_den3_r;
  logic signed [W:0]   mag_ext;

  assign a_ext  = {a_i[W-1], a_i};
  assign b_ext  = {b_i[W-1], b_i};
  assign lo_ext = {lo_i[W-1], lo_i};
  assign hi_ext = {hi_i[W-1], hi_i};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      a_in1_r <= (a_i >= lo_i) && (a_i <= hi_i);
      b_in1_r <= (b_i >= lo_i) && (b_i <= hi_i);
      d1_r    <= b_ext - a_ext;
      n1_1_r  <= lo_ext - a_ext;
      n2_1_r  <= hi_ext - a_ext;
    end
  end

  // Flip the axis when the segment runs backward so the denominator is positive
  assign dir_neg = d1_r[W];
  assign d_neg   = -d1_r;
  assign n1_neg  = -n1_1_r;
  assign n2_neg  = -n2_1_r;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      a_in2_r <= a_in1_r;
      b_in2_r <= b_in1_r;
      zero2_r <= (d1_r == '0);
      mag2_r  <= dir_neg ? d_neg[W-1:0] : d1_r[W-1:0];
      f1_2_r  <= dir_neg ? n2_neg : n1_1_r;
      f2_2_r  <= dir_neg ? n1_neg : n2_1_r;
    end
  end

  assign mag_ext = $signed({1'b0, mag2_r});

  always_ff @(posedge clk) begin
    if (en.s3) begin
      a_in3_r <= a_in2_r;
      b_in3_r <= b_in2_r;
      if (zero2_r) begin
        // no motion on this axis: plain range check of the start point
        miss3_r   <= !a_in2_r;
        lo_num3_r <= '0;
        lo_den3_r <= W'(1);
        hi_num3_r <= W'(1);
        hi_den3_r <= W'(1);
      end else begin
        miss3_r <= f2_2_r[W] || (f1_2_r > mag_ext);
        if (f1_2_r[W]) begin
          lo_num3_r <= '0;
          lo_den3_r <= W'(1);
        end else begin
          lo_num3_r <= f1_2_r[W-1:0];
          lo_den3_r <= mag2_r;
        end
        if (f2_2_r >= mag_ext) begin
          hi_num3_r <= W'(1);
          hi_den3_r <= W'(1);
        end else begin
          hi_num3_r <= f2_2_r[W-1:0];
          hi_den3_r <= mag2_r;
        end
      end
    end
  end

  assign t_lo_num = lo_num3_r;
  assign t_lo_den = lo_den3_r;
  assign t_hi_num = hi_num3_r;
  assign t_hi_den = hi_den3_r;
  assign miss     = miss3_r;
  assign a_in     = a_in3_r;
  assign b_in     = b_in3_r;

endmodule

/* hw/rtl/sbi_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_cmp
// Cross-axis interval overlap: cross-multiplies the clamped parameters of
// both axes, then forms the hit and inside flags.
// ----------------------------------------------------------------------------
module sbi_cmp #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  sbi_pkg::pipe_en_t     en,
  input  logic [COORD_BITS-1:0] x_lo_num,
  input  logic [COORD_BITS-1:0] x_lo_den,
  input  logic [COORD_BITS-1:0] x_hi_num,
  input  logic [COORD_BITS-1:0] x_hi_den,
  input  logic [COORD_BITS-1:0] y_lo_num,
  input  logic [COORD_BITS-1:0] y_lo_den,
  input  logic [COORD_BITS-1:0] y_hi_num,
  input  logic [COORD_BITS-1:0] y_hi_den,
  input  logic                  x_miss,
  input  logic                  y_miss,
  input  logic                  start_in,
  input  logic                  end_in,
  output logic                  hit,
  output logic                  start_inside,
  output logic                  end_inside
);
  import sbi_pkg::*;

  localparam int PW = 2 * COORD_BITS;

  logic [PW-1:0] xlo_yhi_r, yhi_xlo_r, ylo_xhi_r, xhi_ylo_r;
  logic          miss4_r, start_in4_r, end_in4_r;
  logic          hit5_r, start_in5_r, end_in5_r;

  // x entry <= y exit and y entry <= x exit, by cross-multiplication
  always_ff @(posedge clk) begin
    if (en.s4) begin
      xlo_yhi_r   <= PW'(x_lo_num) * PW'(y_hi_den);
      yhi_xlo_r   <= PW'(y_hi_num) * PW'(x_lo_den);
      ylo_xhi_r   <= PW'(y_lo_num) * PW'(x_hi_den);
      xhi_ylo_r   <= PW'(x_hi_num) * PW'(y_lo_den);
      miss4_r     <= x_miss || y_miss;
      start_in4_r <= start_in;
      end_in4_r   <= end_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      hit5_r      <= start_in4_r || end_in4_r ||
                     (!miss4_r && (xlo_yhi_r <= yhi_xlo_r) && (ylo_xhi_r <= xhi_ylo_r));
      start_in5_r <= start_in4_r;
      end_in5_r   <= end_in4_r;
    end
  end

  assign hit          = hit5_r;
  assign start_inside = start_in5_r;
  assign end_inside   = end_in5_r;

endmodule
